[rtl/srm_pkg.sv]
// Shared types, constants and helpers for the same-bank refresh management block.
`default_nettype none

package srm_pkg;

   // Memory organization.
   localparam int RANKS           = 2;
   localparam int BANK_GROUPS     = 8;
   localparam int BANKS_PER_GROUP = 4;
   localparam int TOTAL_BANKS     = RANKS * BANK_GROUPS * BANKS_PER_GROUP;
   localparam int IDX_W           = (TOTAL_BANKS > 1) ? $clog2(TOTAL_BANKS) : 1;

   // Counter and threshold format.
   localparam int          CNT_W         = 16;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [15:0] THRESH_RESET  = 16'd256;

   // One issued DRAM command.
   typedef struct packed {
      logic       is_activate;
      logic [0:0] rank;
      logic [2:0] bank_group;
      logic [1:0] bank;
   } req_type;

   // One same-bank refresh management request.
   typedef struct packed {
      logic [0:0] rfm_rank;
      logic [1:0] rfm_bank;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a command and read its counter
      logic update;     // write back the counter or clear the bank index
      logic cfg_write;  // write the threshold register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic trigger;    // the current activate reaches the threshold
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   // Flat counter index of a rank, bank group and bank.
   function automatic logic [IDX_W-1:0] bank_index(input int unsigned rk,
                                                   input int unsigned bg,
                                                   input int unsigned bk);
      int unsigned flat;
      flat = (rk * BANK_GROUPS + bg) * BANKS_PER_GROUP + bk;
      return IDX_W'(flat);
   endfunction

endpackage

`default_nettype wire

[rtl/srm_ctrl.sv]
// Controller state machine that sequences counter read and update for each command.
`default_nettype none

module srm_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   output logic                 rsp_strobe,
   output srm_pkg::cmd_type     cmd,
   input  srm_pkg::status_type  status
);

   srm_pkg::state_type state_ff, state_in;
   logic               strobe_ff, strobe_in;

   // Next state: a command takes the read cycle in idle, then the update state, then returns to idle.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = srm_pkg::ST_UPDATE;
            end
         end
         srm_pkg::ST_UPDATE: begin
            state_in = srm_pkg::ST_IDLE;
         end
         default: begin
            state_in = srm_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.load      = (state_ff == srm_pkg::ST_IDLE) && start;
      cmd.update    = (state_ff == srm_pkg::ST_UPDATE);
      cmd.cfg_write = csr_valid && csr_ready;
   end

   // The result strobe follows an update that reached the threshold.
   assign strobe_in = cmd.update && status.trigger;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= srm_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == srm_pkg::ST_UPDATE);
   assign csr_ready  = ~busy;
   assign rsp_strobe = strobe_ff;

   // An accepted command always moves to the update cycle.
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == srm_pkg::ST_UPDATE))
      else $error("accepted command did not enter update");

   // The update state always returns to idle in the next cycle.
   a_update_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srm_pkg::ST_UPDATE) |=> (state_ff == srm_pkg::ST_IDLE))
      else $error("update cycle did not return to idle");

   // A result strobe is only produced right after an update cycle.
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == srm_pkg::ST_UPDATE))
      else $error("result strobe without a preceding update");

endmodule

`default_nettype wire

[rtl/srm_dpath.sv]
// Datapath with the activation counter RAM, valid bits, threshold and result register.
`default_nettype none

module srm_dpath (
   input  wire                   clock,
   input  wire                   reset,
   input  srm_pkg::req_type      req_data,
   input  wire [15:0]            csr_data,
   output srm_pkg::rsp_type      rsp_data,
   input  srm_pkg::cmd_type      cmd,
   output srm_pkg::status_type   status
);

   // Counter storage; an entry whose valid bit is clear reads as zero.
   logic [srm_pkg::CNT_W-1:0]       cnt_mem [srm_pkg::TOTAL_BANKS];
   logic [srm_pkg::TOTAL_BANKS-1:0] valid_ff, valid_in;

   srm_pkg::req_type            req_ff;
   logic                        range_ok_ff;
   logic [srm_pkg::IDX_W-1:0]   idx_ff;
   logic [srm_pkg::CNT_W-1:0]   rd_cnt_ff;
   logic                        rd_valid_ff;
   logic [srm_pkg::CNT_W-1:0]   thresh_ff;
   srm_pkg::rsp_type            rsp_ff;

   logic                        range_ok;
   logic [srm_pkg::IDX_W-1:0]   rd_idx;
   logic [srm_pkg::CNT_W-1:0]   cur_cnt;
   logic [srm_pkg::CNT_W-1:0]   new_cnt;
   logic                        counting;
   logic                        trigger;

   // Address check and flat index of the incoming command.
   assign range_ok = (32'(req_data.rank) < 32'(srm_pkg::RANKS)) &&
                     (32'(req_data.bank_group) < 32'(srm_pkg::BANK_GROUPS)) &&
                     (32'(req_data.bank) < 32'(srm_pkg::BANKS_PER_GROUP));
   assign rd_idx = srm_pkg::bank_index(32'(req_data.rank), 32'(req_data.bank_group),
                                       32'(req_data.bank));

   // Capture the command and read its counter in the same cycle.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         range_ok_ff <= range_ok;
         idx_ff      <= rd_idx;
         rd_cnt_ff   <= cnt_mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   // Saturating increment and threshold compare.
   assign cur_cnt  = rd_valid_ff ? rd_cnt_ff : '0;
   assign new_cnt  = (cur_cnt == srm_pkg::COUNT_MAX) ? cur_cnt
                                                     : cur_cnt + srm_pkg::CNT_W'(1);
   assign counting = req_ff.is_activate && range_ok_ff;
   assign trigger  = counting && (new_cnt >= thresh_ff);
   assign status.trigger = trigger;

   // Write back the counter when it stays below the threshold.
   always_ff @(posedge clock) begin
      if (cmd.update && counting && !trigger) begin
         cnt_mem[idx_ff] <= new_cnt;
      end
   end

   // Valid bits: set on write back, cleared across all bank groups on a trigger.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.update && counting) begin
         if (trigger) begin
            for (int g = 0; g < srm_pkg::BANK_GROUPS; g++) begin
               valid_in[srm_pkg::bank_index(32'(req_ff.rank), g, 32'(req_ff.bank))] = 1'b0;
            end
         end else begin
            valid_in[idx_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         thresh_ff <= srm_pkg::THRESH_RESET;
      end else begin
         valid_ff <= valid_in;
         if (cmd.cfg_write) begin
            thresh_ff <= csr_data;
         end
      end
   end

   // Result register, loaded on every update and shown with the strobe.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff.rfm_rank <= req_ff.rank;
         rsp_ff.rfm_bank <= req_ff.bank;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/same_bank_refresh_management.sv]
// Top level of the same-bank refresh management activation tracker.
`default_nettype none

// A command is handled as follows: in the cycle where start is seen with busy
// low the command is captured and its activation counter is read from the counter
// RAM, and in the next cycle (busy high) the counter is incremented and written back
// or, on reaching the threshold, that bank index is cleared in every bank group of
// the rank. A refresh management request appears on rsp_data for one cycle with
// rsp_strobe, the cycle after the update, and the receiver cannot stall it.
// Counters are cleared at reset through per-entry valid bits, so no clearing pass
// is needed. The threshold is written over the csr channel while busy is low.
module same_bank_refresh_management (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  srm_pkg::req_type   req_data,
   output logic               rsp_strobe,
   output srm_pkg::rsp_type   rsp_data,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire [15:0]         csr_data
);

   srm_pkg::cmd_type    cmd;
   srm_pkg::status_type status;

   // Sequencing.
   srm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // Counters, threshold and result.
   srm_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

`default_nettype wire
